// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/btdb_pkg.sv =====
// ----------------------------------------------------------------------------
// btdb_pkg
// Types and constants of the bulk transfer descriptor builder.
// ----------------------------------------------------------------------------
package btdb_pkg;

  localparam int MP_W   = 11;
  localparam int TLEN_W = 15;
  localparam int TDS_W  = 5;
  localparam int ADDR_W = 32;

  localparam logic [MP_W-1:0]  DEFAULT_PACKET = 11'd512;
  localparam logic [TDS_W-1:0] TDS_CAP        = 5'd31;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_CHUNK = 1'b1;

  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_EVENT  = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG   = 2'd1;
  localparam logic [1:0] STATUS_UNEXPECTED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_BEGIN,
    ST_DIV_CHUNK,
    ST_NORMAL,
    ST_EMPTY,
    ST_EVENT,
    ST_ERROR
  } state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [TLEN_W-1:0] tlen;
    logic [TDS_W-1:0]  tds;
    logic              chain;
    logic              ioc;
    logic              last;
  } desc_t;

endpackage

// ===== src/btdb_div.sv =====
// ----------------------------------------------------------------------------
// btdb_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module btdb_div #(
  parameter int DW = 23
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [DW-1:0]             dividend,
  input  logic [btdb_pkg::MP_W-1:0] divisor,
  output logic                      done,
  output logic [DW-1:0]             quotient,
  output logic [btdb_pkg::MP_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]             quo;
  logic [btdb_pkg::MP_W-1:0] rem;
  logic [btdb_pkg::MP_W-1:0] dvs;
  logic [CNT_W-1:0]          cnt;
  logic                      running;

  logic [btdb_pkg::MP_W:0]   trial;
  logic [btdb_pkg::MP_W:0]   diff;
  logic                      ge;
  logic [btdb_pkg::MP_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[DW-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? diff[btdb_pkg::MP_W-1:0] : trial[btdb_pkg::MP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_W'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DW);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= {quo[DW-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== src/btdb_out.sv =====
// ----------------------------------------------------------------------------
// btdb_out
// Output register for descriptors; frees itself when the sink takes one.
// ----------------------------------------------------------------------------
module btdb_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  btdb_pkg::desc_t  desc_in,
  output logic             free,
  output logic             valid,
  input  logic             ready,
  output btdb_pkg::desc_t  desc_out
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      desc_out <= desc_in;
    end
  end

endmodule

// ===== src/bulk_transfer_descriptor_builder_unit.sv =====
// ----------------------------------------------------------------------------
// bulk_transfer_descriptor_builder_unit
// Builds chained normal, empty and closing event data descriptors, or an error descriptor, for bulk requests.
// ----------------------------------------------------------------------------
//  channel  dir  tuser            tlast        tdata
//  s_axis   in   opcode           -            length..chunk_address (112 b)
//  m_axis   out  descriptor_kind  last         status..ioc (56 b)
//
//  Begin: taken on acceptance, or, when the zero packet check runs, once the
//  serial divider (W = remaining-byte width) has finished. Chunk: a divide for
//  the TD size, then each result goes to the output register as it frees.
//  The bit-serial divider produces one quotient bit a cycle.
//  Reset is synchronous; no memory, no clearing pass. A stalled sink holds
//  the block in its emit states; no request is taken until the last result
//  is in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bulk_transfer_descriptor_builder_unit #(
  parameter int CHUNK_BYTES = 20480,
  parameter int MAX_CHUNKS  = 252
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // length[31:0], max_packet[42:32], is_read[43], add_zero[44],
  // request_tag[76:45], chunk_address[108:77], zero pad
  input  logic [111:0] s_axis_tdata,
  // opcode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], buffer_address[33:2], transfer_length[48:34],
  // td_size[53:49], chain[54], interrupt_on_completion[55]
  output logic [55:0]  m_axis_tdata,
  // descriptor_kind
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int unsigned LIMIT_BYTES = MAX_CHUNKS * CHUNK_BYTES;
  localparam int W  = $clog2(LIMIT_BYTES + 1);
  localparam int CW = $clog2(CHUNK_BYTES + 1);

  // request fields
  logic                      in_op;
  logic [31:0]               in_len;
  logic [btdb_pkg::MP_W-1:0] in_mp;
  logic                      in_rd;
  logic                      in_az;
  logic [31:0]               in_tag;
  logic [31:0]               in_addr;

  assign in_op   = s_axis_tuser;
  assign in_len  = s_axis_tdata[31:0];
  assign in_mp   = s_axis_tdata[42:32];
  assign in_rd   = s_axis_tdata[43];
  assign in_az   = s_axis_tdata[44];
  assign in_tag  = s_axis_tdata[76:45];
  assign in_addr = s_axis_tdata[108:77];

  btdb_pkg::state_t state, state_next;

  logic                      busy;
  logic [W-1:0]              bytes_rem;
  logic [btdb_pkg::MP_W-1:0] packet_size;
  logic                      zlp_pending;
  logic [31:0]               saved_tag;
  logic [31:0]               chunk_addr;
  logic [CW-1:0]             chunk_len;
  logic [1:0]                err_code;

  logic                      accept;
  logic                      too_long;
  logic                      need_zlp_div;
  logic [btdb_pkg::MP_W-1:0] mp_eff;
  logic [CW-1:0]             take;
  logic [W-1:0]              rem_after;

  logic                      div_start;
  logic                      div_done;
  logic [W-1:0]              div_dividend;
  logic [btdb_pkg::MP_W-1:0] div_divisor;
  logic [W-1:0]              div_quo;
  logic [btdb_pkg::MP_W-1:0] div_rem;
  logic [btdb_pkg::TDS_W-1:0] tds;

  logic                      out_load;
  logic                      out_free;
  btdb_pkg::desc_t           out_desc;
  btdb_pkg::desc_t           m_desc;

  assign s_axis_tready = (state == btdb_pkg::ST_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign too_long     = in_len > 32'(LIMIT_BYTES);
  assign mp_eff       = (in_mp == '0) ? btdb_pkg::DEFAULT_PACKET : in_mp;
  assign need_zlp_div = (in_len != '0) && !in_rd && in_az;
  assign take         = (bytes_rem < W'(CHUNK_BYTES)) ? CW'(bytes_rem) : CW'(CHUNK_BYTES);
  assign rem_after    = bytes_rem - W'(take);

  // TD size = ceil(rem / mp), capped
  always_comb begin
    if (div_quo >= W'(btdb_pkg::TDS_CAP)) begin
      tds = btdb_pkg::TDS_CAP;
    end else begin
      tds = div_quo[btdb_pkg::TDS_W-1:0] +
            {{(btdb_pkg::TDS_W-1){1'b0}}, (div_rem != '0)};
    end
  end

  // divider launch
  always_comb begin
    div_start    = 1'b0;
    div_dividend = rem_after;
    div_divisor  = packet_size;
    if (accept) begin
      if (in_op == btdb_pkg::OP_BEGIN) begin
        div_start    = !too_long && need_zlp_div;
        div_dividend = in_len[W-1:0];
        div_divisor  = mp_eff;
      end else begin
        div_start = busy;
      end
    end
  end

  btdb_div #(
    .DW (W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      btdb_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op == btdb_pkg::OP_BEGIN) begin
            if (too_long) begin
              state_next = btdb_pkg::ST_ERROR;
            end else if (in_len == '0) begin
              state_next = btdb_pkg::ST_EMPTY;
            end else if (need_zlp_div) begin
              state_next = btdb_pkg::ST_DIV_BEGIN;
            end
          end else if (!busy) begin
            state_next = btdb_pkg::ST_ERROR;
          end else begin
            state_next = btdb_pkg::ST_DIV_CHUNK;
          end
        end
      end
      btdb_pkg::ST_DIV_BEGIN: begin
        if (div_done) state_next = btdb_pkg::ST_IDLE;
      end
      btdb_pkg::ST_DIV_CHUNK: begin
        if (div_done) state_next = btdb_pkg::ST_NORMAL;
      end
      btdb_pkg::ST_NORMAL: begin
        if (out_free) begin
          if (bytes_rem != '0) begin
            state_next = btdb_pkg::ST_IDLE;
          end else if (zlp_pending) begin
            state_next = btdb_pkg::ST_EMPTY;
          end else begin
            state_next = btdb_pkg::ST_EVENT;
          end
        end
      end
      btdb_pkg::ST_EMPTY: begin
        if (out_free) state_next = btdb_pkg::ST_EVENT;
      end
      btdb_pkg::ST_EVENT, btdb_pkg::ST_ERROR: begin
        if (out_free) state_next = btdb_pkg::ST_IDLE;
      end
      default: state_next = btdb_pkg::ST_IDLE;
    endcase
  end

  // result selection
  always_comb begin
    out_load       = 1'b0;
    out_desc       = '0;
    out_desc.status = btdb_pkg::STATUS_OK;
    out_desc.kind   = btdb_pkg::KIND_NORMAL;
    case (state)
      btdb_pkg::ST_NORMAL: begin
        out_load       = 1'b1;
        out_desc.addr  = chunk_addr;
        out_desc.tlen  = btdb_pkg::TLEN_W'(chunk_len);
        out_desc.tds   = tds;
        out_desc.chain = 1'b1;
        out_desc.last  = (bytes_rem != '0);
      end
      btdb_pkg::ST_EMPTY: begin
        out_load       = 1'b1;
        out_desc.chain = 1'b1;
      end
      btdb_pkg::ST_EVENT: begin
        out_load      = 1'b1;
        out_desc.kind = btdb_pkg::KIND_EVENT;
        out_desc.addr = saved_tag;
        out_desc.ioc  = 1'b1;
        out_desc.last = 1'b1;
      end
      btdb_pkg::ST_ERROR: begin
        out_load        = 1'b1;
        out_desc.status = err_code;
        out_desc.last   = 1'b1;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= btdb_pkg::ST_IDLE;
      busy        <= 1'b0;
      zlp_pending <= 1'b0;
      packet_size <= btdb_pkg::DEFAULT_PACKET;
    end else begin
      state <= state_next;
      if (accept && (in_op == btdb_pkg::OP_BEGIN)) begin
        busy        <= !too_long && (in_len != '0);
        zlp_pending <= 1'b0;
        if (!too_long) packet_size <= mp_eff;
      end
      if ((state == btdb_pkg::ST_DIV_BEGIN) && div_done) begin
        zlp_pending <= (div_rem == '0);
      end
      if ((state == btdb_pkg::ST_NORMAL) && out_free && (bytes_rem == '0)) begin
        busy <= 1'b0;
      end
      if ((state == btdb_pkg::ST_EVENT) && out_free) begin
        zlp_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_op == btdb_pkg::OP_BEGIN) begin
        err_code <= btdb_pkg::STATUS_TOO_LONG;
        if (!too_long) begin
          saved_tag <= in_tag;
          bytes_rem <= in_len[W-1:0];
        end
      end else if (!busy) begin
        err_code <= btdb_pkg::STATUS_UNEXPECTED;
      end else begin
        chunk_addr <= in_addr;
        chunk_len  <= take;
        bytes_rem  <= rem_after;
      end
    end
  end

  btdb_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .desc_in  (out_desc),
    .free     (out_free),
    .valid    (m_axis_tvalid),
    .ready    (m_axis_tready),
    .desc_out (m_desc)
  );

  assign m_axis_tdata = {m_desc.ioc, m_desc.chain, m_desc.tds, m_desc.tlen,
                         m_desc.addr, m_desc.status};
  assign m_axis_tuser = m_desc.kind;
  assign m_axis_tlast = m_desc.last;

  `ASSERT_IMPLIES(a_div_done_in_div, clk, rst, div_done,
    (state == btdb_pkg::ST_DIV_BEGIN) || (state == btdb_pkg::ST_DIV_CHUNK),
    "divider finished outside a divide state")
  `ASSERT_IMPLIES(a_event_is_last, clk, rst, m_axis_tvalid && m_axis_tuser,
    m_axis_tlast && m_axis_tdata[55] && !m_axis_tdata[54], "malformed event descriptor")
  `ASSERT_NEXT(a_event_clears_busy, clk, rst,
    (state == btdb_pkg::ST_EVENT) && out_free, !busy && !zlp_pending,
    "request still open after event descriptor")
  `ASSERT_IMPLIES(a_chunk_needs_busy, clk, rst,
    (state == btdb_pkg::ST_DIV_CHUNK) || (state == btdb_pkg::ST_NORMAL), busy,
    "chunk descriptor built without an open request")

endmodule
